// ===== rtl/pdds_pkg.sv =====
// Shared types and constants of the differential drive PID steering block.
package pdds_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam int unsigned ERR_W       = 17;
	localparam int unsigned MS_W        = 32;
	localparam int unsigned PROD_W      = 48;
	localparam int unsigned INC_W       = 26;
	localparam int unsigned INC_Q_W     = 17;
	localparam int unsigned RECIP_W     = 29;
	localparam int unsigned RECIP_SHIFT = 38;
	localparam int unsigned SCALE_W     = 10;
	localparam int unsigned DER_DIV_W   = 27;
	localparam int unsigned DER_W       = 28;
	localparam int unsigned ACC_W       = 46;
	localparam int unsigned CORR_W      = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P     = 3'd0,
		REG_GAIN_I     = 3'd1,
		REG_GAIN_D     = 3'd2,
		REG_SETPOINT   = 3'd3,
		REG_BASE_SPEED = 3'd4
	} reg_idx_t;

	localparam logic [15:0]        GAIN_P_RST   = 16'd512;
	localparam logic [15:0]        GAIN_I_RST   = 16'd0;
	localparam logic [15:0]        GAIN_D_RST   = 16'd128;
	localparam logic signed [15:0] SETPOINT_RST = 16'sd0;
	localparam logic [7:0]         BASE_RST     = 8'd110;

	localparam logic signed [15:0]   INTEG_LIMIT = 16'sd25600;
	localparam logic [SCALE_W-1:0]   MS_PER_S    = 10'd1000;
	localparam logic signed [23:0]   CORR_MAX    = 24'sh7FFFFF;
	localparam logic signed [23:0]   CORR_MIN    = 24'sh800000;
	localparam logic [7:0]           DUTY_MAX    = 8'd255;

	// cap the product just past the point where the integral clamps anyway
	localparam logic [INC_W-1:0]     INC_CAP     = 26'd51201000;
	localparam logic [RECIP_W-1:0]   RECIP_1000  = 29'd274877907;

	typedef struct packed {
		logic load;
		logic mul;
		logic div_start;
		logic integ;
		logic prod;
		logic sum;
		logic emit;
	} pdds_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_stall;
	} pdds_status_t;

endpackage

// ===== rtl/pdds_in_if.sv =====
// Request channel carrying one offset sample and its timestamp.
interface pdds_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] offset_sample;
	logic [31:0]        timestamp_ms;

	modport source (output valid, output offset_sample, output timestamp_ms, input ready);
	modport sink (input valid, input offset_sample, input timestamp_ms, output ready);
endinterface

// ===== rtl/pdds_out_if.sv =====
// Request channel carrying the motor duties and the PID correction.
interface pdds_out_if;
	logic               valid;
	logic               ready;
	logic [7:0]         left_duty;
	logic [7:0]         right_duty;
	logic signed [23:0] correction_out;

	modport source (output valid, output left_duty, output right_duty,
		output correction_out, input ready);
	modport sink (input valid, input left_duty, input right_duty,
		input correction_out, output ready);
endinterface

// ===== rtl/pid_differential_drive_steer.sv =====
// Top level of the PID steering controller for a differential drive.
//
// The sample channel takes one request: a signed Q8.8 lateral offset and a
// millisecond timestamp. The steer channel returns one request per sample:
// left and right PWM duties and the signed Q16.8 correction.
// Gains, setpoint and base speed are written through cfg_we/cfg_index/
// cfg_data; the user must write them only while no sample is in flight,
// as the block itself does not enforce this. Unknown indexes are dropped.
// One sample is in work at a time: a new sample is taken only once the
// previous result is in the output register. The derivative is divided
// by the elapsed time in a 27-step serial divide; the integral increment
// is divided by 1000 with a reciprocal multiply alongside it.
// The finished result sits in an output register; the block accepts the
// next sample while it waits, and holds a newer result until the receiver
// takes the older one.
// Reset clears the integral, last error and last timestamp and restores
// the register defaults; no clearing pass is needed.
module pid_differential_drive_steer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pdds_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdds_pkg::CFG_DATA_W-1:0] cfg_data,
	pdds_in_if.sink                         sample,
	pdds_out_if.source                      steer
);
	import pdds_pkg::*;

	pdds_cmd_t    cmd;
	pdds_status_t status;

	pdds_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.status   (status),
		.cmd      (cmd)
	);

	pdds_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.status         (status),
		.offset_sample  (sample.offset_sample),
		.timestamp_ms   (sample.timestamp_ms),
		.out_ready      (steer.ready),
		.out_valid      (steer.valid),
		.left_duty      (steer.left_duty),
		.right_duty     (steer.right_duty),
		.correction_out (steer.correction_out)
	);

endmodule

// ===== rtl/pdds_divider.sv =====
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
module pdds_divider #(
	parameter int unsigned W  = 48,
	parameter int unsigned DW = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [W-1:0]  dividend,
	input  logic [DW-1:0] divisor,
	output logic [W-1:0]  quotient,
	output logic          busy,
	output logic          done
);

	localparam int unsigned CW = $clog2(W + 1);

	logic [W-1:0]  rq_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [DW:0]   shifted;
	logic [DW:0]   trial;
	logic          ge;

	assign shifted = {rem_q, rq_q[W-1]};
	assign trial   = shifted - {1'b0, div_q};
	assign ge      = !trial[DW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rq_q  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rq_q  <= {rq_q[W-2:0], ge};
			rem_q <= ge ? trial[DW-1:0] : shifted[DW-1:0];
		end
	end

	assign quotient = rq_q;
	assign busy     = busy_q;
	assign done     = done_q;

	assert property (@(posedge clk) disable iff (!arst_n) !(busy_q && done_q))
		else $error("divider busy and done at once");

endmodule

// ===== rtl/pdds_datapath.sv =====
// Datapath: configuration registers, PID arithmetic, state and result register.
module pdds_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [pdds_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdds_pkg::CFG_DATA_W-1:0] cfg_data,
	input  pdds_pkg::pdds_cmd_t          cmd,
	output pdds_pkg::pdds_status_t       status,
	input  logic signed [15:0]           offset_sample,
	input  logic [31:0]                  timestamp_ms,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [7:0]                   left_duty,
	output logic [7:0]                   right_duty,
	output logic signed [23:0]           correction_out
);
	import pdds_pkg::*;

	logic [15:0]        gain_p_q;
	logic [15:0]        gain_i_q;
	logic [15:0]        gain_d_q;
	logic signed [15:0] setpoint_q;
	logic [7:0]         base_q;

	logic signed [ERR_W-1:0] last_err_q;
	logic signed [15:0]      integral_q;
	logic [MS_W-1:0]         last_ts_q;

	logic signed [ERR_W-1:0] err_q;
	logic [MS_W-1:0]         ms_q;
	logic [INC_W-1:0]        prod_mag_q;
	logic [INC_Q_W-1:0]      inc_mag_q;
	logic [DER_DIV_W-1:0]    dscaled_q;
	logic                    inc_neg_q;
	logic                    der_neg_q;
	logic signed [DER_W-1:0] deriv_q;
	logic signed [33:0]      pp_q;
	logic signed [32:0]      pi_q;
	logic signed [44:0]      pd_q;
	logic signed [CORR_W-1:0] corr_q;

	logic               out_valid_q;
	logic [7:0]         left_q;
	logic [7:0]         right_q;
	logic signed [23:0] corr_out_q;

	logic [MS_W-1:0]         elapsed;
	logic [ERR_W-1:0]        err_abs;
	logic [PROD_W-1:0]       prod_w;
	logic [INC_W-1:0]        prod_sat;
	logic [INC_W+RECIP_W-1:0] inc_recip;
	logic [ERR_W:0]          diff;
	logic [ERR_W:0]          diff_abs;
	logic [DER_DIV_W-1:0]    dscaled_w;
	logic [DER_DIV_W-1:0]    q_der;
	logic                    der_busy;
	logic                    der_done;
	logic [INC_Q_W:0]        inc_s;
	logic signed [INC_Q_W+1:0] isum;
	logic signed [15:0]      integ_w;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] acc_b;
	logic [37:0]             corr_t;
	logic signed [CORR_W-1:0] corr_w;
	logic [25:0]             lsum;
	logic [25:0]             rsum;

	function automatic logic [7:0] duty_of(input logic [25:0] v);
		logic [7:0] d;
		if (v[25]) begin
			d = 8'd0;
		end else if (|v[24:16]) begin
			d = DUTY_MAX;
		end else begin
			d = v[15:8];
		end
		return d;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q   <= GAIN_P_RST;
			gain_i_q   <= GAIN_I_RST;
			gain_d_q   <= GAIN_D_RST;
			setpoint_q <= SETPOINT_RST;
			base_q     <= BASE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_P: begin
					gain_p_q <= cfg_data;
				end
				REG_GAIN_I: begin
					gain_i_q <= cfg_data;
				end
				REG_GAIN_D: begin
					gain_d_q <= cfg_data;
				end
				REG_SETPOINT: begin
					setpoint_q <= $signed(cfg_data);
				end
				REG_BASE_SPEED: begin
					base_q <= cfg_data[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign elapsed   = timestamp_ms - last_ts_q;
	assign err_abs   = err_q[ERR_W-1] ? (~err_q + ERR_W'(1)) : err_q;
	assign prod_w    = err_abs[15:0] * ms_q;
	assign prod_sat  = (prod_w > {{(PROD_W-INC_W){1'b0}}, INC_CAP}) ? INC_CAP
		: prod_w[INC_W-1:0];
	assign inc_recip = prod_mag_q * RECIP_1000;
	assign diff      = {err_q[ERR_W-1], err_q} - {last_err_q[ERR_W-1], last_err_q};
	assign diff_abs  = diff[ERR_W] ? (~diff + (ERR_W+1)'(1)) : diff;
	assign dscaled_w = diff_abs[ERR_W-1:0] * MS_PER_S;

	pdds_divider #(.W(DER_DIV_W), .DW(MS_W)) u_div_der (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dscaled_q),
		.divisor  (ms_q),
		.quotient (q_der),
		.busy     (der_busy),
		.done     (der_done)
	);

	assign inc_s = inc_neg_q ? (~{1'b0, inc_mag_q} + (INC_Q_W+1)'(1)) : {1'b0, inc_mag_q};
	assign isum  = $signed({{3{integral_q[15]}}, integral_q}) + $signed({inc_s[INC_Q_W], inc_s});

	always_comb begin
		if (isum > $signed({{3{INTEG_LIMIT[15]}}, INTEG_LIMIT})) begin
			integ_w = INTEG_LIMIT;
		end else if (isum < -$signed({{3{INTEG_LIMIT[15]}}, INTEG_LIMIT})) begin
			integ_w = -INTEG_LIMIT;
		end else begin
			integ_w = isum[15:0];
		end
	end

	assign acc    = $signed({{12{pp_q[33]}}, pp_q}) + $signed({{13{pi_q[32]}}, pi_q})
		+ $signed({pd_q[44], pd_q});
	assign acc_b  = acc + (acc[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
	assign corr_t = acc_b[ACC_W-1:8];

	always_comb begin
		if ((corr_t[37:23] == '0) || (corr_t[37:23] == '1)) begin
			corr_w = $signed(corr_t[23:0]);
		end else begin
			corr_w = corr_t[37] ? CORR_MIN : CORR_MAX;
		end
	end

	assign lsum = {10'd0, base_q, 8'd0} + {{2{corr_q[23]}}, corr_q};
	assign rsum = {10'd0, base_q, 8'd0} - {{2{corr_q[23]}}, corr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q <= '0;
			integral_q <= '0;
			last_ts_q  <= '0;
		end else if (cmd.load) begin
			last_ts_q <= timestamp_ms;
		end else if (cmd.integ) begin
			last_err_q <= err_q;
			integral_q <= integ_w;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			err_q <= {setpoint_q[15], setpoint_q} - {offset_sample[15], offset_sample};
			ms_q  <= (elapsed == '0) ? MS_W'(1) : elapsed;
		end
		if (cmd.mul) begin
			prod_mag_q <= prod_sat;
			dscaled_q  <= dscaled_w;
			inc_neg_q  <= err_q[ERR_W-1];
			der_neg_q  <= diff[ERR_W];
		end
		if (cmd.div_start) begin
			inc_mag_q <= inc_recip[RECIP_SHIFT +: INC_Q_W];
		end
		if (cmd.integ) begin
			deriv_q <= der_neg_q ? (~{1'b0, q_der} + DER_W'(1)) : {1'b0, q_der};
		end
		if (cmd.prod) begin
			pp_q <= $signed({1'b0, gain_p_q}) * err_q;
			pi_q <= $signed({1'b0, gain_i_q}) * integral_q;
			pd_q <= $signed({1'b0, gain_d_q}) * deriv_q;
		end
		if (cmd.sum) begin
			corr_q <= corr_w;
		end
		if (cmd.emit) begin
			left_q     <= duty_of(lsum);
			right_q    <= duty_of(rsum);
			corr_out_q <= corr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.div_done  = der_done;
	assign status.out_stall = out_valid_q && !out_ready;

	assign out_valid      = out_valid_q;
	assign left_duty      = left_q;
	assign right_duty     = right_q;
	assign correction_out = corr_out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(integral_q <= INTEG_LIMIT) && (integral_q >= -INTEG_LIMIT))
		else $error("integral out of clamp range");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid_q && !out_ready))
		else $error("result overwritten while pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !der_busy)
		else $error("divide started while busy");

endmodule

// ===== rtl/pdds_controller.sv =====
// Controller: sequences one sample through the datapath.
module pdds_controller (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  pdds_pkg::pdds_status_t status,
	output pdds_pkg::pdds_cmd_t    cmd
);
	import pdds_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_MUL   = 8'b0000_0010,
		ST_DIV   = 8'b0000_0100,
		ST_WAIT  = 8'b0000_1000,
		ST_INTEG = 8'b0001_0000,
		ST_PROD  = 8'b0010_0000,
		ST_SUM   = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_start = 1'b1;
				state_d       = ST_WAIT;
			end
			ST_WAIT: begin
				if (status.div_done) begin
					state_d = ST_INTEG;
				end
			end
			ST_INTEG: begin
				cmd.integ = 1'b1;
				state_d   = ST_PROD;
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				state_d  = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!status.out_stall) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

endmodule
